>>> rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg: shared types and codes for the Mobius sieve square-free counter
// Command and result beats, divider request and response, and fixed codes.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam logic [1:0] FUNC_BUILD  = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_COUNT  = 2'd2;
  localparam logic [1:0] FUNC_KTH    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [1:0] MU_ZERO = 2'b00;
  localparam logic [1:0] MU_POS  = 2'b01;
  localparam logic [1:0] MU_NEG  = 2'b11;

  localparam int          KTH_MARGIN = 50;
  localparam logic [16:0] CFG_RESET  = 17'd65536;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic signed [1:0] mobius_value;
    logic [16:0]       core_value;
    logic              is_square_free;
    logic [31:0]       number_result;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/msf_ram.sv
// ----------------------------------------------------------------------------
// msf_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/msf_div.sv
// ----------------------------------------------------------------------------
// msf_div: 32-bit restoring divider
// One quotient bit per cycle; done pulses when the last quotient bit is in.
// ----------------------------------------------------------------------------
module msf_div (
  input  logic              clk,
  input  logic              rst,
  input  msf_pkg::div_req_t req,
  output msf_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        den  <= req.divisor;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> rtl/mobius_sieve_square_free_counter_top.sv
// ----------------------------------------------------------------------------
// mobius_sieve_square_free_counter_top: Mobius sieve and square-free counter
// Linear sieve into RAM tables, lookup, square-free count and k-th search.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (valid/stall) carries one command beat: func and operand_value.
//   rsp (valid/stall) returns exactly one result beat per command.
//   cfg (valid/ready, ready always high) writes sieve_limit and marks the
//   tables unbuilt; write it only while the block is idle.
//   One command is in work at a time; cmd_stall is high while it runs.
//   A finished result waits in the rsp register while the next command is
//   taken; a stalled rsp holds the block in its final state until it drains.
// Work per command (L = effective limit):
//   lookup reads the info table at the operand; errors go straight to the result.
//   build runs a clear pass over entries 0..L, then works through each index
//   and each sieve write, dividing the core by p for each write that needs it
//   (on the shared divider).
//   count steps k up to isqrt(N), with one divide for each k with mu(k) != 0.
//   kth runs count up to 33 times over the binary search.
// Reset clears control state and the built flag; limit returns to 65536.
// The tables need no clearing pass: build clears the factor table itself.
// ----------------------------------------------------------------------------
module mobius_sieve_square_free_counter_top #(
  parameter int MAX_N       = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  msf_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output msf_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [16:0]   cfg_data
);

  localparam int LW  = $clog2(MAX_N + 1);
  localparam int PW  = $clog2(PRIME_SLOTS);
  localparam int CW  = $clog2(PRIME_SLOTS + 1);
  localparam int IW  = LW + 3;
  localparam int SQW = 2 * (LW + 1);
  localparam int PRW = 2 * LW;
  localparam int KW  = 2 * LW + 2;
  localparam logic [LW-1:0] MAXN_L  = LW'(MAX_N);
  localparam logic [CW-1:0] SLOTS_C = CW'(PRIME_SLOTS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WAIT  = 5'd1;
  localparam logic [4:0] S_CHECK = 5'd2;
  localparam logic [4:0] S_LKA   = 5'd3;
  localparam logic [4:0] S_LKB   = 5'd4;
  localparam logic [4:0] B_CLR   = 5'd5;
  localparam logic [4:0] B_RD_I  = 5'd6;
  localparam logic [4:0] B_GOT_I = 5'd7;
  localparam logic [4:0] B_RD_P  = 5'd8;
  localparam logic [4:0] B_MUL   = 5'd9;
  localparam logic [4:0] B_CHK   = 5'd10;
  localparam logic [4:0] B_DIV   = 5'd11;
  localparam logic [4:0] B_WR    = 5'd12;
  localparam logic [4:0] B_NEXT  = 5'd13;
  localparam logic [4:0] C_INIT  = 5'd14;
  localparam logic [4:0] C_K     = 5'd15;
  localparam logic [4:0] C_CMP   = 5'd16;
  localparam logic [4:0] C_DIV   = 5'd17;
  localparam logic [4:0] C_END   = 5'd18;
  localparam logic [4:0] K_LOOP  = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [4:0]       state;
  logic [1:0]       func;
  logic [31:0]      opv;
  logic [16:0]      cfg_lim;
  logic             built;
  logic [LW-1:0]    lim;
  logic [LW:0]      lim1;
  logic [SQW-1:0]   limsq;
  msf_pkg::rsp_t    res;

  logic [LW-1:0]    c;
  logic [LW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    pc;
  logic [LW-1:0]    spf_i;
  logic [1:0]       mu_i;
  logic             sf_i;
  logic [LW-1:0]    core_i;
  logic [LW-1:0]    p;
  logic [PRW-1:0]   prod;
  logic [PRW-1:0]   cp;

  logic [LW:0]      k;
  logic [KW-1:0]    kk;
  logic [1:0]       mu_k;
  logic [31:0]      cn;
  logic signed [34:0] sum;
  logic [31:0]      cnt;
  logic [32:0]      lo;
  logic [32:0]      hi;
  logic [32:0]      ans;
  logic [32:0]      mid;
  logic [32:0]      mid_next;
  logic [33:0]      hi_w;
  logic [32:0]      hi0;

  logic             spf_we;
  logic [LW-1:0]    spf_waddr;
  logic [LW-1:0]    spf_wdata;
  logic [LW-1:0]    spf_rd;
  logic             info_we;
  logic [LW-1:0]    info_waddr;
  logic [IW-1:0]    info_wdata;
  logic [LW-1:0]    info_raddr;
  logic [IW-1:0]    info_rd;
  logic             pr_we;
  logic [PW-1:0]    pr_waddr;
  logic [LW-1:0]    pr_wdata;
  logic [LW-1:0]    pr_rd;

  logic             new_prime;
  logic             room;
  logic             sieve_stop;
  logic             k_over;
  logic [1:0]       mu_rd;

  msf_pkg::div_req_t div_req;
  msf_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    if (cfg_lim == 17'd0) begin
      lim = LW'(1);
    end else if (32'(cfg_lim) > 32'(MAX_N)) begin
      lim = MAXN_L;
    end else begin
      lim = LW'(cfg_lim);
    end
  end

  assign lim1       = {1'b0, lim} + (LW + 1)'(1);
  assign new_prime  = (spf_rd == '0);
  assign room       = (pc != SLOTS_C);
  assign sieve_stop = (p > spf_i) || (prod > PRW'(lim));
  assign k_over     = (kk > KW'(cn));
  assign mu_rd      = info_rd[IW-1:IW-2];
  assign cnt        = sum[34] ? 32'd0 : sum[31:0];
  assign mid_next   = lo + ((hi - lo) >> 1);
  assign hi_w       = {1'b0, opv, 1'b0} + 34'(msf_pkg::KTH_MARGIN);
  assign hi0        = hi_w[32:0];

  // table write and read ports
  always_comb begin
    spf_we     = 1'b0;
    spf_waddr  = c;
    spf_wdata  = '0;
    info_we    = 1'b0;
    info_waddr = c;
    info_wdata = '0;
    pr_we      = 1'b0;
    pr_waddr   = pc[PW-1:0];
    pr_wdata   = i;
    info_raddr = i;
    case (state)
      B_CLR: begin
        spf_we  = 1'b1;
        info_we = (c <= LW'(1));
        if (c != '0) begin
          info_wdata = {msf_pkg::MU_POS, 1'b1, LW'(1)};
        end
      end
      B_GOT_I: begin
        if (new_prime && room) begin
          spf_we     = 1'b1;
          spf_waddr  = i;
          spf_wdata  = i;
          info_we    = 1'b1;
          info_waddr = i;
          info_wdata = {msf_pkg::MU_NEG, 1'b1, i};
          pr_we      = 1'b1;
        end
      end
      B_WR: begin
        spf_we     = 1'b1;
        spf_waddr  = prod[LW-1:0];
        spf_wdata  = p;
        info_we    = 1'b1;
        info_waddr = prod[LW-1:0];
        if (p == spf_i) begin
          info_wdata = {msf_pkg::MU_ZERO, 1'b0,
                        (div_rsp.remainder == 32'd0) ? div_rsp.quotient[LW-1:0]
                                                     : cp[LW-1:0]};
        end else begin
          info_wdata = {2'(~mu_i + 2'd1), sf_i, cp[LW-1:0]};
        end
      end
      C_K:     info_raddr = k[LW-1:0];
      S_LKA:   info_raddr = opv[LW-1:0];
      default: info_raddr = i;
    endcase
  end

  always_comb begin
    div_req.start    = ((state == B_CHK) && !sieve_stop && (p == spf_i)) ||
                       ((state == C_CMP) && !k_over && (mu_rd != msf_pkg::MU_ZERO));
    div_req.dividend = (state == C_CMP) ? cn : 32'(core_i);
    div_req.divisor  = (state == C_CMP) ? 32'(kk) : 32'(p);
  end

  always_ff @(posedge clk) begin
    limsq <= SQW'(lim1) * SQW'(lim1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      built     <= 1'b0;
      cfg_lim   <= msf_pkg::CFG_RESET;
      rsp_valid <= 1'b0;
      pc        <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_lim <= cfg_data;
        built   <= 1'b0;
      end
      if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            func  <= cmd.func;
            opv   <= cmd.operand_value;
            res   <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_CHECK;
        S_CHECK: begin
          if (func == msf_pkg::FUNC_BUILD) begin
            c     <= '0;
            pc    <= '0;
            built <= 1'b0;
            state <= B_CLR;
          end else if (!built) begin
            res.status <= msf_pkg::ST_NOT_BUILT;
            state      <= S_DONE;
          end else if (func == msf_pkg::FUNC_LOOKUP) begin
            if ((opv == 32'd0) || (opv > 32'(lim))) begin
              res.status <= msf_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              state <= S_LKA;
            end
          end else if (func == msf_pkg::FUNC_COUNT) begin
            if (64'(opv) >= 64'(limsq)) begin
              res.status <= msf_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              cn    <= opv;
              state <= C_INIT;
            end
          end else begin
            if ((hi_w[33:32] != 2'b00) || (64'(hi0) >= 64'(limsq))) begin
              res.status <= msf_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              lo    <= 33'd1;
              hi    <= hi0;
              ans   <= hi0;
              state <= K_LOOP;
            end
          end
        end
        S_LKA: state <= S_LKB;
        S_LKB: begin
          res.mobius_value   <= mu_rd;
          res.is_square_free <= info_rd[LW];
          res.core_value     <= 17'(info_rd[LW-1:0]);
          state              <= S_DONE;
        end
        B_CLR: begin
          c <= c + LW'(1);
          if (c == lim) begin
            if (lim == LW'(1)) begin
              built <= 1'b1;
              state <= S_DONE;
            end else begin
              i     <= LW'(2);
              state <= B_RD_I;
            end
          end
        end
        B_RD_I: state <= B_GOT_I;
        B_GOT_I: begin
          j <= '0;
          if (new_prime && !room) begin
            // prime list full: abandon the build
            res.status <= msf_pkg::ST_RANGE;
            state      <= S_DONE;
          end else if (new_prime) begin
            spf_i  <= i;
            mu_i   <= msf_pkg::MU_NEG;
            sf_i   <= 1'b1;
            core_i <= i;
            pc     <= pc + CW'(1);
            state  <= B_RD_P;
          end else begin
            spf_i  <= spf_rd;
            mu_i   <= mu_rd;
            sf_i   <= info_rd[LW];
            core_i <= info_rd[LW-1:0];
            state  <= B_RD_P;
          end
        end
        B_RD_P: begin
          state <= (j == pc) ? B_NEXT : B_MUL;
        end
        B_MUL: begin
          p     <= pr_rd;
          prod  <= PRW'(i) * PRW'(pr_rd);
          cp    <= PRW'(core_i) * PRW'(pr_rd);
          state <= B_CHK;
        end
        B_CHK: begin
          if (sieve_stop) begin
            state <= B_NEXT;
          end else if (p == spf_i) begin
            state <= B_DIV;
          end else begin
            state <= B_WR;
          end
        end
        B_DIV: begin
          if (div_rsp.done) begin
            state <= B_WR;
          end
        end
        B_WR: begin
          if (p == spf_i) begin
            state <= B_NEXT;
          end else begin
            j     <= j + CW'(1);
            state <= B_RD_P;
          end
        end
        B_NEXT: begin
          if (i == lim) begin
            built <= 1'b1;
            state <= S_DONE;
          end else begin
            i     <= i + LW'(1);
            state <= B_RD_I;
          end
        end
        C_INIT: begin
          k     <= (LW + 1)'(1);
          sum   <= '0;
          state <= C_K;
        end
        C_K: begin
          kk    <= KW'(k) * KW'(k);
          state <= C_CMP;
        end
        C_CMP: begin
          mu_k <= mu_rd;
          if (k_over) begin
            state <= C_END;
          end else if (mu_rd == msf_pkg::MU_ZERO) begin
            k     <= k + (LW + 1)'(1);
            state <= C_K;
          end else begin
            state <= C_DIV;
          end
        end
        C_DIV: begin
          if (div_rsp.done) begin
            if (mu_k == msf_pkg::MU_POS) begin
              sum <= sum + $signed({3'b000, div_rsp.quotient});
            end else begin
              sum <= sum - $signed({3'b000, div_rsp.quotient});
            end
            k     <= k + (LW + 1)'(1);
            state <= C_K;
          end
        end
        C_END: begin
          if (func == msf_pkg::FUNC_COUNT) begin
            res.number_result <= cnt;
            state             <= S_DONE;
          end else begin
            if (cnt >= opv) begin
              ans <= mid;
              hi  <= mid - 33'd1;
            end else begin
              lo <= mid + 33'd1;
            end
            state <= K_LOOP;
          end
        end
        K_LOOP: begin
          if (lo > hi) begin
            res.number_result <= ans[31:0];
            state             <= S_DONE;
          end else begin
            mid   <= mid_next;
            cn    <= mid_next[31:0];
            state <= C_INIT;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  msf_ram #(.WIDTH(LW), .DEPTH(MAX_N + 1)) u_spf_ram (
    .clk   (clk),
    .we    (spf_we),
    .waddr (spf_waddr),
    .wdata (spf_wdata),
    .raddr (i),
    .rdata (spf_rd)
  );

  msf_ram #(.WIDTH(IW), .DEPTH(MAX_N + 1)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (info_raddr),
    .rdata (info_rd)
  );

  msf_ram #(.WIDTH(LW), .DEPTH(PRIME_SLOTS)) u_prime_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (j[PW-1:0]),
    .rdata (pr_rd)
  );

  msf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
